/* rtl/mmm_pkg.sv */
// ----------------------------------------------------------------------------
// mmm_pkg
// Shared types, constants and helpers for the matrix multiply block.
// ----------------------------------------------------------------------------
package mmm_pkg;

  localparam int unsigned MAX_DIM_DEF   = 8;
  localparam int unsigned ELEM_BITS_DEF = 16;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned DIM_W   = 4;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD_A  = 2'd0,
    FN_LOAD_B  = 2'd1,
    FN_COMPUTE = 2'd2,
    FN_NONE    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_MAC   = 2'd1,
    ST_DRAIN = 2'd2,
    ST_EMIT  = 2'd3
  } state_e;

  // control travelling down the cell chain with each A element
  typedef struct packed {
    logic valid;
    logic first;
  } mac_ctl_t;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int unsigned m);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (32'(v) > m) r = DIM_W'(m);
    return r;
  endfunction

endpackage

/* rtl/mmm_if.sv */
// ----------------------------------------------------------------------------
// mmm_in_if / mmm_out_if
// Valid/ready channels for commands and product elements.
// ----------------------------------------------------------------------------
interface mmm_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [mmm_pkg::FUNC_W-1:0]            func;
  logic [mmm_pkg::IDX_W-1:0]             row;
  logic [mmm_pkg::IDX_W-1:0]             col;
  logic signed [mmm_pkg::VALUE_W-1:0]    value;

  modport source (output valid, func, row, col, value, input ready);
  modport sink   (input valid, func, row, col, value, output ready);
endinterface

interface mmm_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [mmm_pkg::IDX_W-1:0]             out_row;
  logic [mmm_pkg::IDX_W-1:0]             out_col;
  logic signed [mmm_pkg::SUM_W-1:0]      sum;
  logic                                  last;

  modport source (output valid, out_row, out_col, sum, last, input ready);
  modport sink   (input valid, out_row, out_col, sum, last, output ready);
endinterface

/* rtl/mmm_cell.sv */
// ----------------------------------------------------------------------------
// mmm_cell
// One product column: holds a B column, multiplies the passing A element
// and accumulates, then forwards the A element to the next cell.
// ----------------------------------------------------------------------------
module mmm_cell #(
  parameter int unsigned MAX_DIM   = mmm_pkg::MAX_DIM_DEF,
  parameter int unsigned ELEM_BITS = mmm_pkg::ELEM_BITS_DEF,
  parameter int unsigned IW        = $clog2(MAX_DIM)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              b_we_i,
  input  logic [IW-1:0]                     b_row_i,
  input  logic signed [ELEM_BITS-1:0]       b_data_i,
  input  mmm_pkg::mac_ctl_t                 ctl_i,
  input  logic [IW-1:0]                     k_i,
  input  logic signed [ELEM_BITS-1:0]       a_i,
  output mmm_pkg::mac_ctl_t                 ctl_o,
  output logic [IW-1:0]                     k_o,
  output logic signed [ELEM_BITS-1:0]       a_o,
  output logic signed [mmm_pkg::SUM_W-1:0]  acc_o
);
  import mmm_pkg::*;

  logic signed [ELEM_BITS-1:0]   b_q [MAX_DIM];
  logic signed [2*ELEM_BITS-1:0] prod;
  logic signed [SUM_W-1:0]       acc_q, acc_d;
  mac_ctl_t                      ctl_q;
  logic [IW-1:0]                 k_q;
  logic signed [ELEM_BITS-1:0]   a_q;

  always_ff @(posedge clk_i) begin
    if (b_we_i) begin
      b_q[b_row_i] <= b_data_i;
    end
  end

  assign prod  = a_i * b_q[k_i];
  assign acc_d = (ctl_i.first ? SUM_W'(0) : acc_q) + SUM_W'(prod);

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      acc_q <= acc_d;
    end
    k_q <= k_i;
    a_q <= a_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  assign ctl_o = ctl_q;
  assign k_o   = k_q;
  assign a_o   = a_q;
  assign acc_o = acc_q;

`ifndef ASSERT_OFF
  a_fwd_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.valid |=> ctl_o.valid && k_o == $past(k_i))
    else $error("cell did not forward element");
  a_first_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.valid && ctl_i.first |=> acc_o === SUM_W'($past(prod)))
    else $error("first element did not restart sum");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl_i.valid |=> acc_o === $past(acc_o))
    else $error("sum changed without element");
`endif

endmodule

/* rtl/matrix_matrix_multiply.sv */
// ----------------------------------------------------------------------------
// matrix_matrix_multiply
// Loads A and B elements, then streams A*B row-major through a chain of
// MAC cells, one cell per product column.
//
//   channel | dir | handshake         | payload
//   in_if   | in  | valid/ready       | func, row, col, value
//   out_if  | out | valid/ready       | out_row, out_col, sum, last
//   apb     | in  | psel/penable/pwrite | paddr, pwdata -> prdata
//
// Loads are written as they are accepted. A compute runs, for each product
// row, nk A reads from the A memory, a drain while the last element ripples
// through the cell chain, and the emit of the row's nc elements.
// Commands are not accepted while a compute runs. Output stalls hold the
// emit sequence. No clearing pass after reset.
// ----------------------------------------------------------------------------
module matrix_matrix_multiply #(
  parameter int unsigned MAX_DIM   = mmm_pkg::MAX_DIM_DEF,
  parameter int unsigned ELEM_BITS = mmm_pkg::ELEM_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mmm_in_if.sink                          in_if,
  mmm_out_if.source                       out_if,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mmm_pkg::PADDR_W-1:0]     paddr,
  input  logic [mmm_pkg::PDATA_W-1:0]     pwdata,
  output logic [mmm_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);
  import mmm_pkg::*;

  localparam int unsigned IW    = $clog2(MAX_DIM);
  localparam int unsigned AW    = $clog2(MAX_DIM * MAX_DIM);
  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;

  // configuration
  logic [DIM_W-1:0] rows_q, inner_q, cols_q;
  logic             cfg_we;
  reg_idx_e         cfg_idx;
  logic [DIM_W-1:0] nr, nk, nc;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= DIM_W'(8);
      inner_q <= DIM_W'(8);
      cols_q  <= DIM_W'(8);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ROWS_A:    rows_q  <= pwdata[DIM_W-1:0];
        REG_INNER_DIM: inner_q <= pwdata[DIM_W-1:0];
        REG_COLS_B:    cols_q  <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_ROWS_A:    prdata = PDATA_W'(rows_q);
      REG_INNER_DIM: prdata = PDATA_W'(inner_q);
      REG_COLS_B:    prdata = PDATA_W'(cols_q);
      default:       prdata = '0;
    endcase
    if (paddr[1:0] != 2'b00) prdata = '0;
  end

  assign nr = clamp_dim(rows_q, MAX_DIM);
  assign nk = clamp_dim(inner_q, MAX_DIM);
  assign nc = clamp_dim(cols_q, MAX_DIM);

  // command decode
  state_e                      state_q, state_d;
  logic                        in_acc, load_ok;
  func_e                       func;
  logic signed [ELEM_BITS-1:0] elem;
  logic [AW-1:0]               wr_addr, rd_addr;

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign func        = func_e'(in_if.func);
  assign load_ok     = (32'(in_if.row) < MAX_DIM) && (32'(in_if.col) < MAX_DIM);
  assign elem        = ELEM_BITS'(in_if.value);
  assign wr_addr     = AW'(32'(in_if.row) * MAX_DIM + 32'(in_if.col));

  // A memory
  logic signed [ELEM_BITS-1:0] a_mem_q [DEPTH];
  logic signed [ELEM_BITS-1:0] a_rd_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && func == FN_LOAD_A && load_ok) begin
      a_mem_q[wr_addr] <= elem;
    end
    a_rd_q <= a_mem_q[rd_addr];
  end

  // sequencer
  logic [DIM_W-1:0] r_q, r_d, k_q, k_d, c_q, c_d;
  logic [IW-1:0]    wait_q, wait_d;
  mac_ctl_t         iss_q, iss_d;
  logic [IW-1:0]    iss_k_q;
  logic             out_load, out_free;

  assign rd_addr  = AW'(32'(r_q) * MAX_DIM + 32'(k_q));
  assign out_free = !out_if.valid || out_if.ready;

  always_comb begin
    state_d  = state_q;
    r_d      = r_q;
    k_d      = k_q;
    c_d      = c_q;
    wait_d   = wait_q;
    iss_d    = '0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && func == FN_COMPUTE) begin
          state_d = ST_MAC;
          r_d     = '0;
          k_d     = '0;
        end
      end
      ST_MAC: begin
        iss_d.valid = 1'b1;
        iss_d.first = (k_q == '0);
        if (k_q == nk - DIM_W'(1)) begin
          state_d = ST_DRAIN;
          wait_d  = '0;
        end else begin
          k_d = k_q + DIM_W'(1);
        end
      end
      ST_DRAIN: begin
        if (wait_q == IW'(MAX_DIM - 1)) begin
          state_d = ST_EMIT;
          c_d     = '0;
        end else begin
          wait_d = wait_q + IW'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (c_q == nc - DIM_W'(1)) begin
            if (r_q == nr - DIM_W'(1)) begin
              state_d = ST_IDLE;
            end else begin
              state_d = ST_MAC;
              r_d     = r_q + DIM_W'(1);
              k_d     = '0;
            end
          end else begin
            c_d = c_q + DIM_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      r_q     <= '0;
      k_q     <= '0;
      c_q     <= '0;
      wait_q  <= '0;
      iss_q   <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      k_q     <= k_d;
      c_q     <= c_d;
      wait_q  <= wait_d;
      iss_q   <= iss_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iss_k_q <= k_q[IW-1:0];
  end

  // cell chain
  mac_ctl_t                    ctl_w [MAX_DIM+1];
  logic [IW-1:0]               k_w   [MAX_DIM+1];
  logic signed [ELEM_BITS-1:0] a_w   [MAX_DIM+1];
  logic signed [SUM_W-1:0]     acc_w [MAX_DIM];

  assign ctl_w[0] = iss_q;
  assign k_w[0]   = iss_k_q;
  assign a_w[0]   = a_rd_q;

  for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
    logic b_we;
    assign b_we = in_acc && func == FN_LOAD_B && load_ok && 32'(in_if.col) == g;
    mmm_cell #(
      .MAX_DIM  (MAX_DIM),
      .ELEM_BITS(ELEM_BITS),
      .IW       (IW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .b_we_i  (b_we),
      .b_row_i (in_if.row[IW-1:0]),
      .b_data_i(elem),
      .ctl_i   (ctl_w[g]),
      .k_i     (k_w[g]),
      .a_i     (a_w[g]),
      .ctl_o   (ctl_w[g+1]),
      .k_o     (k_w[g+1]),
      .a_o     (a_w[g+1]),
      .acc_o   (acc_w[g])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.valid <= 1'b0;
    end else if (out_load) begin
      out_if.valid <= 1'b1;
    end else if (out_if.ready) begin
      out_if.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_if.out_row <= IDX_W'(r_q);
      out_if.out_col <= IDX_W'(c_q);
      out_if.sum     <= acc_w[c_q[IW-1:0]];
      out_if.last    <= (r_q == nr - DIM_W'(1)) && (c_q == nc - DIM_W'(1));
    end
  end

`ifndef ASSERT_OFF
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_if.valid)
    else $error("loaded result not presented");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |-> !out_load)
    else $error("pending result overwritten");
  a_issue_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss_q.valid |-> $past(state_q) == ST_MAC)
    else $error("element issued outside MAC phase");
  a_chain_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_w[MAX_DIM].valid |-> state_q != ST_IDLE)
    else $error("chain active while idle");
`endif

endmodule
